/* sv/assert_macros.svh */
// assertion macros shared by the run statistics rtl
// needs clk and rst_n in the module that uses them
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// checked while out of reset
`define UDRS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked at every edge, reset included
`define UDRS_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define UDRS_ASSERT(label, prop, msg)
`define UDRS_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

/* sv/udrs_pkg.sv */
// shared types and constants of the up/down run statistics block
// no dependencies
package udrs_pkg;

    // work codes passed from the front to the back
    typedef enum logic [2:0] {
        OP_START = 3'd0,
        OP_RISE  = 3'd1,
        OP_FALL  = 3'd2,
        OP_LEVEL = 3'd3,
        OP_CLOSE = 3'd4
    } op_t;

    // trend of the open sequence
    typedef enum logic [1:0] {
        PHASE_LEVEL = 2'd0,
        PHASE_RISE  = 2'd1,
        PHASE_FALL  = 2'd2
    } phase_t;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

endpackage

/* sv/udrs_if.sv */
// valid/ready channel interfaces for samples and statistics
// no dependencies
interface udrs_in_if #(
    parameter int SAMPLE_BITS = 16
);
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] sample;
    logic                   end_marker;

    modport source (output valid, output sample, output end_marker, input ready);
    modport sink   (input valid, input sample, input end_marker, output ready);
endinterface

interface udrs_out_if #(
    parameter int COUNT_BITS = 16
);
    logic                  valid;
    logic                  ready;
    logic [COUNT_BITS-1:0] value_count;
    logic [COUNT_BITS-1:0] up_runs;
    logic [COUNT_BITS-1:0] up_length_sum;
    logic [COUNT_BITS-1:0] down_runs;
    logic [COUNT_BITS-1:0] down_length_sum;

    modport source (output valid, output value_count, output up_runs, output up_length_sum,
                    output down_runs, output down_length_sum, input ready);
    modport sink   (input valid, input value_count, input up_runs, input up_length_sum,
                    input down_runs, input down_length_sum, output ready);
endinterface

/* sv/udrs_queue.sv */
// two-entry work queue between front and back
// depends on udrs_pkg
`include "assert_macros.svh"

module udrs_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push_valid,
    input  udrs_pkg::op_t  push_op,
    output logic           push_ready,
    output logic           op_valid,
    output udrs_pkg::op_t  op,
    input  logic           pop
);

    udrs_pkg::op_t                          entry_reg [udrs_pkg::QUEUE_DEPTH];
    logic [udrs_pkg::QUEUE_PTR_BITS-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [udrs_pkg::QUEUE_PTR_BITS-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [udrs_pkg::QUEUE_CNT_BITS-1:0]    count_reg, count_next;
    logic                                   push;

    localparam logic [udrs_pkg::QUEUE_PTR_BITS-1:0] LAST_PTR =
        udrs_pkg::QUEUE_PTR_BITS'(udrs_pkg::QUEUE_DEPTH - 1);
    localparam logic [udrs_pkg::QUEUE_CNT_BITS-1:0] FULL_COUNT =
        udrs_pkg::QUEUE_CNT_BITS'(udrs_pkg::QUEUE_DEPTH);

    assign push_ready = (count_reg != FULL_COUNT);
    assign push       = push_valid && push_ready;
    assign op_valid   = (count_reg != '0);
    assign op         = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_op;
        end
    end

    `UDRS_ASSERT(a_no_pop_empty, pop |-> op_valid, "queue popped while empty")
    `UDRS_ASSERT(a_count_bound, count_reg <= FULL_COUNT, "queue fill count out of range")

endmodule

/* sv/udrs_front.sv */
// front end: accepts samples, tracks sequence framing, classifies each step
// depends on udrs_pkg and udrs_in_if
`include "assert_macros.svh"

module udrs_front #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic           clk,
    input  logic           rst_n,
    udrs_in_if.sink        samples,
    output logic           push_valid,
    output udrs_pkg::op_t  push_op,
    input  logic           push_ready
);

    logic [SAMPLE_BITS-1:0] prev_reg, prev_next;
    logic                   open_reg, open_next;
    logic                   accept;

    assign samples.ready = push_ready;
    assign accept        = samples.valid && push_ready;

    always_comb
    begin
        push_valid = 1'b0;
        push_op    = udrs_pkg::OP_LEVEL;
        prev_next  = prev_reg;
        open_next  = open_reg;
        if (accept)
        begin
            if (samples.end_marker)
            begin
                // stray marker with nothing open is dropped
                push_valid = open_reg;
                push_op    = udrs_pkg::OP_CLOSE;
                open_next  = 1'b0;
            end
            else if (!open_reg)
            begin
                push_valid = 1'b1;
                push_op    = udrs_pkg::OP_START;
                open_next  = 1'b1;
                prev_next  = samples.sample;
            end
            else
            begin
                push_valid = 1'b1;
                prev_next  = samples.sample;
                if (samples.sample > prev_reg)
                begin
                    push_op = udrs_pkg::OP_RISE;
                end
                else if (samples.sample < prev_reg)
                begin
                    push_op = udrs_pkg::OP_FALL;
                end
                else
                begin
                    push_op = udrs_pkg::OP_LEVEL;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg <= 1'b0;
        end
        else
        begin
            open_reg <= open_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prev_reg <= prev_next;
    end

    `UDRS_ASSERT(a_close_shuts, (accept && samples.end_marker) |=> !open_reg, "sequence still open after end marker")
    `UDRS_ASSERT(a_sample_opens, (accept && !samples.end_marker) |=> open_reg, "sequence not open after sample")

endmodule

/* sv/udrs_back.sv */
// back end: run tracking, saturating totals and the result register
// depends on udrs_pkg and udrs_out_if
`include "assert_macros.svh"

module udrs_back #(
    parameter int COUNT_BITS = 16
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           op_valid,
    input  udrs_pkg::op_t  op,
    output logic           pop,
    udrs_out_if.source     stats
);

    typedef logic [COUNT_BITS-1:0] cnt_t;

    udrs_pkg::phase_t phase_reg, phase_next;
    cnt_t level_reg, level_next;
    cnt_t run_reg, run_next;
    cnt_t count_reg, count_next;
    cnt_t rruns_reg, rruns_next;
    cnt_t rsum_reg, rsum_next;
    cnt_t fruns_reg, fruns_next;
    cnt_t fsum_reg, fsum_next;
    logic out_valid_reg, out_valid_next;
    cnt_t o_count_reg, o_rruns_reg, o_rsum_reg, o_fruns_reg, o_fsum_reg;
    cnt_t close_rruns, close_rsum, close_fruns, close_fsum;
    logic do_close;

    function automatic cnt_t sat_inc(input cnt_t a);
        sat_inc = (a == '1) ? a : a + 1'b1;
    endfunction

    function automatic cnt_t sat_add(input cnt_t a, input cnt_t b);
        logic [COUNT_BITS:0] s;
        s = {1'b0, a} + {1'b0, b};
        sat_add = s[COUNT_BITS] ? '1 : s[COUNT_BITS-1:0];
    endfunction

    // a close needs the result register free or draining this cycle
    assign pop = op_valid &&
                 ((op != udrs_pkg::OP_CLOSE) || !out_valid_reg || stats.ready);
    assign do_close = pop && (op == udrs_pkg::OP_CLOSE);

    // next trend phase
    always_comb
    begin
        phase_next = phase_reg;
        if (pop)
        begin
            unique case (op)
                udrs_pkg::OP_RISE:  phase_next = udrs_pkg::PHASE_RISE;
                udrs_pkg::OP_FALL:  phase_next = udrs_pkg::PHASE_FALL;
                udrs_pkg::OP_LEVEL: phase_next = phase_reg;
                default:            phase_next = udrs_pkg::PHASE_LEVEL;
            endcase
        end
    end

    // totals as they stand once the open run is closed
    always_comb
    begin
        close_rruns = rruns_reg;
        close_rsum  = rsum_reg;
        close_fruns = fruns_reg;
        close_fsum  = fsum_reg;
        if (phase_reg == udrs_pkg::PHASE_RISE)
        begin
            close_rruns = sat_inc(rruns_reg);
            close_rsum  = sat_add(rsum_reg, run_reg);
        end
        else if (phase_reg == udrs_pkg::PHASE_FALL)
        begin
            close_fruns = sat_inc(fruns_reg);
            close_fsum  = sat_add(fsum_reg, run_reg);
        end
    end

    // counters and totals
    always_comb
    begin
        level_next = level_reg;
        run_next   = run_reg;
        count_next = count_reg;
        rruns_next = rruns_reg;
        rsum_next  = rsum_reg;
        fruns_next = fruns_reg;
        fsum_next  = fsum_reg;
        if (pop)
        begin
            unique case (op)
                udrs_pkg::OP_START:
                begin
                    level_next = '0;
                    run_next   = '0;
                    count_next = COUNT_BITS'(1);
                    rruns_next = '0;
                    rsum_next  = '0;
                    fruns_next = '0;
                    fsum_next  = '0;
                end
                udrs_pkg::OP_RISE:
                begin
                    count_next = sat_inc(count_reg);
                    unique case (phase_reg)
                        udrs_pkg::PHASE_RISE: run_next = sat_inc(run_reg);
                        udrs_pkg::PHASE_FALL:
                        begin
                            fruns_next = close_fruns;
                            fsum_next  = close_fsum;
                            run_next   = COUNT_BITS'(1);
                        end
                        default:
                        begin
                            // leading level steps join the first run
                            run_next   = sat_inc(level_reg);
                            level_next = '0;
                        end
                    endcase
                end
                udrs_pkg::OP_FALL:
                begin
                    count_next = sat_inc(count_reg);
                    unique case (phase_reg)
                        udrs_pkg::PHASE_FALL: run_next = sat_inc(run_reg);
                        udrs_pkg::PHASE_RISE:
                        begin
                            rruns_next = close_rruns;
                            rsum_next  = close_rsum;
                            run_next   = COUNT_BITS'(1);
                        end
                        default:
                        begin
                            run_next   = sat_inc(level_reg);
                            level_next = '0;
                        end
                    endcase
                end
                udrs_pkg::OP_LEVEL:
                begin
                    count_next = sat_inc(count_reg);
                    if (phase_reg == udrs_pkg::PHASE_RISE || phase_reg == udrs_pkg::PHASE_FALL)
                    begin
                        run_next = sat_inc(run_reg);
                    end
                    else
                    begin
                        level_next = sat_inc(level_reg);
                    end
                end
                default:
                begin
                    // close: everything back to the idle values
                    level_next = '0;
                    run_next   = '0;
                    count_next = '0;
                    rruns_next = '0;
                    rsum_next  = '0;
                    fruns_next = '0;
                    fsum_next  = '0;
                end
            endcase
        end
    end

    // result register handshake
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (do_close)
        begin
            out_valid_next = 1'b1;
        end
        else if (stats.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= udrs_pkg::PHASE_LEVEL;
            level_reg     <= '0;
            run_reg       <= '0;
            count_reg     <= '0;
            rruns_reg     <= '0;
            rsum_reg      <= '0;
            fruns_reg     <= '0;
            fsum_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            level_reg     <= level_next;
            run_reg       <= run_next;
            count_reg     <= count_next;
            rruns_reg     <= rruns_next;
            rsum_reg      <= rsum_next;
            fruns_reg     <= fruns_next;
            fsum_reg      <= fsum_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_close)
        begin
            o_count_reg <= count_reg;
            o_rruns_reg <= close_rruns;
            o_rsum_reg  <= close_rsum;
            o_fruns_reg <= close_fruns;
            o_fsum_reg  <= close_fsum;
        end
    end

    assign stats.valid           = out_valid_reg;
    assign stats.value_count     = o_count_reg;
    assign stats.up_runs         = o_rruns_reg;
    assign stats.up_length_sum   = o_rsum_reg;
    assign stats.down_runs       = o_fruns_reg;
    assign stats.down_length_sum = o_fsum_reg;

    `UDRS_ASSERT(a_close_clears, do_close |=> (phase_reg == udrs_pkg::PHASE_LEVEL && count_reg == '0), "state not cleared after close")
    `UDRS_ASSERT(a_close_shows, do_close |=> out_valid_reg, "close gave no result")
    `UDRS_ASSERT(a_level_only_level, (phase_reg != udrs_pkg::PHASE_LEVEL) |-> (level_reg == '0), "level steps left after a direction appeared")

endmodule

/* sv/up_down_run_statistics.sv */
// up/down run statistics: an end marker passes the queue register, and its close in the back sets the result valid
// throughput one item per cycle unless the queue fills; the front takes an item every cycle the queue has room
// a result waiting at the output stalls only a following end marker in the back
// reset is asynchronous active low: no sequence open, queue empty, no result pending
// depends on udrs_pkg, udrs_if, udrs_front, udrs_queue, udrs_back
module up_down_run_statistics #(
    parameter int SAMPLE_BITS = 16,
    parameter int COUNT_BITS  = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    udrs_in_if.sink     samples,
    udrs_out_if.source  stats
);

    // front to queue
    logic           push_valid;
    logic           push_ready;
    udrs_pkg::op_t  push_op;

    // queue to back
    logic           op_valid;
    logic           pop;
    udrs_pkg::op_t  op;

    // front: framing and compare against the previous sample
    udrs_front #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .samples    (samples),
        .push_valid (push_valid),
        .push_op    (push_op),
        .push_ready (push_ready)
    );

    // short queue so the front keeps taking items while the back waits on the output
    udrs_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_op    (push_op),
        .push_ready (push_ready),
        .op_valid   (op_valid),
        .op         (op),
        .pop        (pop)
    );

    // back: run lengths, saturating totals, result register
    udrs_back #(
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .op_valid (op_valid),
        .op       (op),
        .pop      (pop),
        .stats    (stats)
    );

endmodule
